[hw/rtl/pscp_pkg.sv]
// Shared types and constants for the phase scan plateau center block.
`timescale 1ns / 1ps
`default_nettype none

package pscp_pkg;

    localparam int EFF_W   = 17;
    localparam int PHASE_W = 4;
    localparam int OUT_W   = 2;
    localparam int UNIT_W  = EFF_W + 1;

    localparam logic [EFF_W-1:0]   EFF_ONE    = 17'd65536;
    localparam logic [PHASE_W-1:0] NONE_PHASE = 4'd15;

    localparam logic [PHASE_W-1:0] DEFAULT_PHASE_RST = 4'd10;
    localparam logic [PHASE_W-1:0] PHASE_SHIFT_RST   = 4'd4;

    // configuration register indexes
    localparam logic CFG_DEFAULT_PHASE = 1'b0;
    localparam logic CFG_PHASE_SHIFT   = 1'b1;

    // outcome codes
    localparam logic [OUT_W-1:0] OUT_CENTER  = 2'd0;
    localparam logic [OUT_W-1:0] OUT_DEFAULT = 2'd1;
    localparam logic [OUT_W-1:0] OUT_MIN     = 2'd2;
    localparam logic [OUT_W-1:0] OUT_MAX     = 2'd3;

    typedef struct packed {
        logic [EFF_W-1:0] a;
        logic [EFF_W-1:0] b;
        logic             sub;
        logic             cin;
    } unit_req_t;

    typedef struct packed {
        logic [UNIT_W-1:0] sum;
        logic              lt;
        logic              eq;
    } unit_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/phase_scan_plateau_center.sv]
// Top level: phase scan sequencer, scan state and result register.
`timescale 1ns / 1ps
`default_nettype none

// Takes one efficiency word per phase, phases 0 to NUM_PHASES-1 in order, and after the
// last phase of a scan delivers one result word (best_phase, outcome); then a new scan
// starts. Value compares and most decision arithmetic share one adder/comparator under a
// sequencer, so an item of a running scan passes accept, max, min, 1.0 compare and index
// step before the next acceptance, and an item that arrives after the plateau has closed
// passes only accept and index step. The last phase adds the decision steps bgt, mlt,
// sum, dif, wid, ctr and fin. A result waits in the output register while the next scan
// is taken; the decision of the following scan holds only if that register is still full.
module phase_scan_plateau_center #(
    parameter int NUM_PHASES = 15
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_write,
    input  wire                            cfg_index,
    input  wire [pscp_pkg::PHASE_W-1:0]    cfg_data,
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire [pscp_pkg::EFF_W-1:0]      efficiency,
    output logic                           out_valid,
    input  wire                            out_stall,
    output logic [pscp_pkg::PHASE_W-1:0]   best_phase,
    output logic [pscp_pkg::OUT_W-1:0]     outcome
);
    import pscp_pkg::*;

    localparam logic [PHASE_W-1:0] LAST_IDX = PHASE_W'(NUM_PHASES - 1);
    localparam logic [PHASE_W:0]   NUM_EXT  = (PHASE_W + 1)'(NUM_PHASES);

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_MAX  = 12'b0000_0000_0010,
        ST_MIN  = 12'b0000_0000_0100,
        ST_ONE  = 12'b0000_0000_1000,
        ST_CNT  = 12'b0000_0001_0000,
        ST_BGT  = 12'b0000_0010_0000,
        ST_MLT  = 12'b0000_0100_0000,
        ST_SUM  = 12'b0000_1000_0000,
        ST_DIF  = 12'b0001_0000_0000,
        ST_WID  = 12'b0010_0000_0000,
        ST_CTR  = 12'b0100_0000_0000,
        ST_FIN  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [PHASE_W-1:0] default_phase_reg, phase_shift_reg;

    logic [PHASE_W-1:0] phase_index_reg, phase_index_next;
    logic               scan_stopped_reg, scan_stopped_next;
    logic               dip_seen_reg, dip_seen_next;
    logic [EFF_W-1:0]   max_value_reg, max_value_next;
    logic [PHASE_W-1:0] max_phase_reg, max_phase_next;
    logic [EFF_W-1:0]   min_value_reg, min_value_next;
    logic [PHASE_W-1:0] min_phase_reg, min_phase_next;
    logic [PHASE_W-1:0] plateau_start_reg, plateau_start_next;
    logic [PHASE_W-1:0] plateau_end_reg, plateau_end_next;
    logic [EFF_W-1:0]   previous_value_reg, previous_value_next;
    logic [EFF_W-1:0]   before_value_reg, before_value_next;
    logic [EFF_W-1:0]   after_value_reg, after_value_next;

    logic [EFF_W-1:0]   eff_reg, eff_next;

    // decision scratch
    logic               bgt_reg, bgt_next;
    logic               mlt_reg, mlt_next;
    logic [PHASE_W:0]   sum_reg, sum_next;
    logic [PHASE_W-1:0] diff_reg, diff_next;
    logic [PHASE_W-1:0] width_reg, width_next;
    logic [PHASE_W-1:0] center_reg, center_next;

    logic               out_valid_reg, out_valid_next;
    logic [PHASE_W-1:0] best_phase_reg, best_phase_next;
    logic [OUT_W-1:0]   outcome_reg, outcome_next;

    unit_req_t req;
    unit_rsp_t rsp;

    pscp_alu u_alu (
        .req (req),
        .rsp (rsp)
    );

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign best_phase = best_phase_reg;
    assign outcome    = outcome_reg;

    always_comb
    begin
        req.a   = '0;
        req.b   = '0;
        req.sub = 1'b1;
        req.cin = 1'b0;
        unique case (state_reg)
            ST_MAX:
            begin
                req.a = eff_reg;
                req.b = max_value_reg;
            end
            ST_MIN:
            begin
                req.a = eff_reg;
                req.b = min_value_reg;
            end
            ST_ONE:
            begin
                req.a = eff_reg;
                req.b = EFF_ONE;
            end
            ST_BGT:
            begin
                req.a = after_value_reg;
                req.b = before_value_reg;
            end
            ST_MLT:
            begin
                req.a = max_value_reg;
                req.b = EFF_ONE;
            end
            ST_SUM:
            begin
                req.a   = EFF_W'(min_phase_reg);
                req.b   = EFF_W'(phase_shift_reg);
                req.sub = 1'b0;
            end
            ST_DIF:
            begin
                req.a = EFF_W'(min_phase_reg);
                req.b = EFF_W'(phase_shift_reg);
            end
            ST_WID:
            begin
                req.a = EFF_W'(plateau_end_reg);
                req.b = EFF_W'(plateau_start_reg);
            end
            ST_CTR:
            begin
                // an even phase count (odd width_reg) rounds up unless the left neighbor is the better one
                req.a   = EFF_W'(plateau_start_reg);
                req.b   = EFF_W'(width_reg >> 1);
                req.sub = 1'b0;
                req.cin = width_reg[0] & ~bgt_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next          = state_reg;
        phase_index_next    = phase_index_reg;
        scan_stopped_next   = scan_stopped_reg;
        dip_seen_next       = dip_seen_reg;
        max_value_next      = max_value_reg;
        max_phase_next      = max_phase_reg;
        min_value_next      = min_value_reg;
        min_phase_next      = min_phase_reg;
        plateau_start_next  = plateau_start_reg;
        plateau_end_next    = plateau_end_reg;
        previous_value_next = previous_value_reg;
        before_value_next   = before_value_reg;
        after_value_next    = after_value_reg;
        eff_next            = eff_reg;
        bgt_next            = bgt_reg;
        mlt_next            = mlt_reg;
        sum_next            = sum_reg;
        diff_next           = diff_reg;
        width_next          = width_reg;
        center_next         = center_reg;
        out_valid_next      = out_valid_reg & out_stall;
        best_phase_next     = best_phase_reg;
        outcome_next        = outcome_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    eff_next   = efficiency;
                    state_next = scan_stopped_reg ? ST_CNT : ST_MAX;
                end
            end
            ST_MAX:
            begin
                if (max_phase_reg == NONE_PHASE || (!rsp.lt && !rsp.eq))
                begin
                    max_value_next = eff_reg;
                    max_phase_next = phase_index_reg;
                end
                state_next = ST_MIN;
            end
            ST_MIN:
            begin
                if (rsp.lt)
                begin
                    min_value_next = eff_reg;
                    min_phase_next = phase_index_reg;
                end
                state_next = ST_ONE;
            end
            ST_ONE:
            begin
                if (!dip_seen_reg)
                begin
                    if (rsp.lt)
                        dip_seen_next = 1'b1;
                end
                else
                begin
                    if (plateau_start_reg == NONE_PHASE && rsp.eq)
                    begin
                        plateau_start_next = phase_index_reg;
                        before_value_next  = previous_value_reg;
                    end
                    if (plateau_start_reg != NONE_PHASE && plateau_end_reg == NONE_PHASE
                        && rsp.lt)
                    begin
                        plateau_end_next  = phase_index_reg - PHASE_W'(1);
                        after_value_next  = eff_reg;
                        scan_stopped_next = 1'b1;
                    end
                end
                previous_value_next = eff_reg;
                state_next          = ST_CNT;
            end
            ST_CNT:
            begin
                if (phase_index_reg < LAST_IDX)
                begin
                    phase_index_next = phase_index_reg + PHASE_W'(1);
                    state_next       = ST_IDLE;
                end
                else
                begin
                    state_next = ST_BGT;
                end
            end
            ST_BGT:
            begin
                bgt_next   = rsp.lt;
                state_next = ST_MLT;
            end
            ST_MLT:
            begin
                mlt_next   = rsp.lt;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                sum_next   = rsp.sum[PHASE_W:0];
                state_next = ST_DIF;
            end
            ST_DIF:
            begin
                diff_next  = rsp.sum[PHASE_W-1:0];
                state_next = ST_WID;
            end
            ST_WID:
            begin
                width_next = rsp.sum[PHASE_W-1:0];
                state_next = ST_CTR;
            end
            ST_CTR:
            begin
                center_next = rsp.sum[PHASE_W-1:0];
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                // hold while the previous result word is still waiting
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    if (!dip_seen_reg)
                    begin
                        best_phase_next = default_phase_reg;
                        outcome_next    = OUT_DEFAULT;
                    end
                    else if (plateau_end_reg == NONE_PHASE)
                    begin
                        best_phase_next = (sum_reg < NUM_EXT) ? sum_reg[PHASE_W-1:0] : diff_reg;
                        outcome_next    = OUT_MIN;
                    end
                    else if (mlt_reg)
                    begin
                        best_phase_next = max_phase_reg;
                        outcome_next    = OUT_MAX;
                    end
                    else
                    begin
                        best_phase_next = center_reg;
                        outcome_next    = OUT_CENTER;
                    end
                    phase_index_next    = '0;
                    scan_stopped_next   = 1'b0;
                    dip_seen_next       = 1'b0;
                    max_value_next      = '0;
                    max_phase_next      = NONE_PHASE;
                    min_value_next      = EFF_ONE;
                    min_phase_next      = NONE_PHASE;
                    plateau_start_next  = NONE_PHASE;
                    plateau_end_next    = NONE_PHASE;
                    previous_value_next = '0;
                    before_value_next   = '0;
                    after_value_next    = '0;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            default_phase_reg  <= DEFAULT_PHASE_RST;
            phase_shift_reg    <= PHASE_SHIFT_RST;
            phase_index_reg    <= '0;
            scan_stopped_reg   <= 1'b0;
            dip_seen_reg       <= 1'b0;
            max_value_reg      <= '0;
            max_phase_reg      <= NONE_PHASE;
            min_value_reg      <= EFF_ONE;
            min_phase_reg      <= NONE_PHASE;
            plateau_start_reg  <= NONE_PHASE;
            plateau_end_reg    <= NONE_PHASE;
            previous_value_reg <= '0;
            before_value_reg   <= '0;
            after_value_reg    <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            phase_index_reg    <= phase_index_next;
            scan_stopped_reg   <= scan_stopped_next;
            dip_seen_reg       <= dip_seen_next;
            max_value_reg      <= max_value_next;
            max_phase_reg      <= max_phase_next;
            min_value_reg      <= min_value_next;
            min_phase_reg      <= min_phase_next;
            plateau_start_reg  <= plateau_start_next;
            plateau_end_reg    <= plateau_end_next;
            previous_value_reg <= previous_value_next;
            before_value_reg   <= before_value_next;
            after_value_reg    <= after_value_next;
            out_valid_reg      <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_DEFAULT_PHASE: default_phase_reg <= cfg_data;
                    CFG_PHASE_SHIFT:   phase_shift_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload and scratch, no reset needed
    always_ff @(posedge clk)
    begin
        eff_reg        <= eff_next;
        bgt_reg        <= bgt_next;
        mlt_reg        <= mlt_next;
        sum_reg        <= sum_next;
        diff_reg       <= diff_next;
        width_reg      <= width_next;
        center_reg     <= center_next;
        best_phase_reg <= best_phase_next;
        outcome_reg    <= outcome_next;
    end

endmodule

`default_nettype wire

[hw/rtl/pscp_alu.sv]
// Shared add/subtract/compare unit used by the scan sequencer.
`timescale 1ns / 1ps
`default_nettype none

module pscp_alu (
    input  wire pscp_pkg::unit_req_t req,
    output pscp_pkg::unit_rsp_t      rsp
);
    import pscp_pkg::*;

    logic [EFF_W-1:0] b_eff;
    logic             c_eff;

    assign b_eff = req.sub ? ~req.b : req.b;
    assign c_eff = req.sub ? 1'b1 : req.cin;

    always_comb
    begin
        rsp.sum = {1'b0, req.a} + {1'b0, b_eff} + {{(UNIT_W-1){1'b0}}, c_eff};
        // no carry out of a subtract means a borrow
        rsp.lt  = req.sub & ~rsp.sum[UNIT_W-1];
        rsp.eq  = req.sub & (rsp.sum[EFF_W-1:0] == '0);
    end

endmodule

`default_nettype wire
